### hdl/cave_automaton_smoothing_step_defines.svh
// Assertion macros shared by the cave smoothing block.
// Both macros sample on the rising edge of i_clk and are off while reset is held.
`ifndef CAVE_AUTOMATON_SMOOTHING_STEP_DEFINES_SVH
`define CAVE_AUTOMATON_SMOOTHING_STEP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cas_pkg.sv
`default_nettype none

package cas_pkg;

    localparam int GRID_WIDTH_W  = 8;
    localparam int GRID_HEIGHT_W = 11;
    localparam int THRESH_W      = 4;
    localparam int COUNT_W       = 4;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 11;
    localparam int WIN_W         = 9;
    localparam int WIN_CENTRE    = 4;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    typedef logic [WIN_W-1:0]       t_window;
    typedef logic [COUNT_W-1:0]     t_count;

    localparam t_cfg_index CFG_GRID_WIDTH  = 3'd0;
    localparam t_cfg_index CFG_GRID_HEIGHT = 3'd1;
    localparam t_cfg_index CFG_SURVIVE_MIN = 3'd2;
    localparam t_cfg_index CFG_BIRTH_MIN   = 3'd3;
    localparam t_cfg_index CFG_EDGE_WALLS  = 3'd4;

    localparam logic MODE_CELL  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST  = 8'd80;
    localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST = 11'd80;
    localparam logic [THRESH_W-1:0]      SURVIVE_MIN_RST = 4'd4;
    localparam logic [THRESH_W-1:0]      BIRTH_MIN_RST   = 4'd5;
    localparam logic                     EDGE_WALLS_RST  = 1'b1;

    // Window bit (column * 3 + row), column 0 is the left one, row 0 the top one.
    localparam t_window MASK_LEFT   = 9'b000_000_111;
    localparam t_window MASK_RIGHT  = 9'b111_000_000;
    localparam t_window MASK_TOP    = 9'b001_001_001;
    localparam t_window MASK_BOTTOM = 9'b100_100_100;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } t_edge_flags;

endpackage

`default_nettype wire

### hdl/cave_automaton_smoothing_step.sv
// One smoothing generation of a cave map, streamed in raster order.
// Input channel (i_in_valid / o_in_stall): one cell per transaction. i_mode 0 carries
// a cell, i_mode 1 is a flush item; i_frame_start on a cell restarts the frame at (0,0).
// After the last cell of a frame send width + 1 flush items to drain the final row.
// Output channel (o_out_valid / i_out_stall): one transaction per judged cell, with its
// column, row and a frame_last flag on the frame's final cell.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready; write only while
// no transaction is in flight.
// Throughput: one item per cycle. An item is read from the line buffers on the edge
// that accepts it, and is judged, written back and any result registered as it
// leaves the judging stage. The result for a cell follows width + 1 items behind it.
// When the receiver stalls, the result register holds and one more item may enter the
// judging stage; the input stalls only when that stage holds a result it cannot pass on.
// Reset clears the frame state, the window and the registers to 80x80, 4/5, edge walls
// on; line buffer contents are not cleared and need not be.
`default_nettype none
`include "cave_automaton_smoothing_step_defines.svh"

module cave_automaton_smoothing_step #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_mode,
    input  logic                               i_cell_wall,
    input  logic                               i_frame_start,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_new_wall,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_out_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]      o_out_row,
    output logic                               o_frame_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cas_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [cas_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import cas_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int WCW = (WW > GRID_WIDTH_W) ? WW : GRID_WIDTH_W;
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int HCW = (RW > GRID_HEIGHT_W) ? RW : GRID_HEIGHT_W;
    localparam int ORW = $clog2(MAX_HEIGHT);

    logic [GRID_WIDTH_W-1:0]  r_grid_width;
    logic [GRID_HEIGHT_W-1:0] r_grid_height;
    logic [THRESH_W-1:0]      r_survive_min;
    logic [THRESH_W-1:0]      r_birth_min;
    logic                     r_edge_walls;

    logic          r_lb_upper [MAX_WIDTH];
    logic          r_lb_middle [MAX_WIDTH];
    logic          r_up_bit;
    logic          r_mid_bit;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_active;
    t_window       r_window;

    logic          r_s1_valid;
    logic          r_s1_emit;
    logic          r_s1_last;
    logic          r_s1_fs;
    logic          r_s1_v;
    logic [CW-1:0] r_s1_col;
    logic [CW-1:0] r_s1_ccol;
    logic [ORW-1:0] r_s1_crow;
    t_edge_flags   r_s1_edges;

    logic           r_out_valid;
    logic           r_new_wall;
    logic [CW-1:0]  r_out_col;
    logic [ORW-1:0] r_out_row;
    logic           r_frame_last;

    logic [WCW-1:0] gw_ext, w_ext, w_m1, c_ext, ccol_ext;
    logic [HCW-1:0] gh_ext, h_ext, h_m1, r_ext, crow_ext;
    logic           fs_eff, a_active, a_v, has, a_end, a_emit, a_last, row_end;
    logic [CW-1:0]  a_col, n_col;
    logic [RW-1:0]  a_row, n_row;
    logic           n_active;
    t_edge_flags    a_edges;
    logic           accept, load_s1, out_free, s1_move;

    t_window        win_base, win_next, mask, cell_bits;
    t_count         count;
    logic           judged;

    always_comb begin
        gw_ext = WCW'(r_grid_width);
        if (gw_ext < WCW'(3)) begin
            w_ext = WCW'(3);
        end else if (gw_ext > WCW'(MAX_WIDTH)) begin
            w_ext = WCW'(MAX_WIDTH);
        end else begin
            w_ext = gw_ext;
        end
        w_m1 = w_ext - WCW'(1);

        gh_ext = HCW'(r_grid_height);
        if (gh_ext < HCW'(3)) begin
            h_ext = HCW'(3);
        end else if (gh_ext > HCW'(MAX_HEIGHT)) begin
            h_ext = HCW'(MAX_HEIGHT);
        end else begin
            h_ext = gh_ext;
        end
        h_m1 = h_ext - HCW'(1);
    end

    always_comb begin
        fs_eff   = (i_mode == MODE_CELL) && i_frame_start;
        a_active = fs_eff || r_active;
        a_v      = (i_mode == MODE_CELL) && i_cell_wall;
        a_col    = fs_eff ? '0 : r_col;
        a_row    = fs_eff ? '0 : r_row;
        c_ext    = WCW'(a_col);
        r_ext    = HCW'(a_row);

        if (a_col != '0 && a_row != '0) begin
            has      = 1'b1;
            crow_ext = r_ext - HCW'(1);
            ccol_ext = c_ext - WCW'(1);
        end else if (a_col == '0 && r_ext >= HCW'(2)) begin
            has      = 1'b1;
            crow_ext = r_ext - HCW'(2);
            ccol_ext = w_m1;
        end else begin
            has      = 1'b0;
            crow_ext = '0;
            ccol_ext = '0;
        end

        row_end = (c_ext + WCW'(1)) >= w_ext;
        n_col   = row_end ? '0 : CW'(c_ext + WCW'(1));
        n_row   = row_end ? a_row + RW'(1) : a_row;

        a_end    = has && (crow_ext >= h_ext);
        a_emit   = has && !a_end && (ccol_ext < w_ext);
        a_last   = a_emit && (crow_ext == h_m1) && (ccol_ext == w_m1);
        n_active = a_active && !a_end && !a_last;

        a_edges.left   = (ccol_ext == '0);
        a_edges.right  = (ccol_ext == w_m1);
        a_edges.top    = (crow_ext == '0);
        a_edges.bottom = (crow_ext == h_m1);
    end

    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_move     = r_s1_valid && (!r_s1_emit || out_free);
    assign o_in_stall  = r_s1_valid && !s1_move;
    assign accept      = i_in_valid && !o_in_stall;
    assign load_s1     = accept && a_active;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        win_base  = r_s1_fs ? '0 : r_window;
        win_next  = {r_s1_v, r_mid_bit, r_up_bit, win_base[WIN_W-1:3]};
        mask      = ({WIN_W{r_s1_edges.left}} & MASK_LEFT)
                  | ({WIN_W{r_s1_edges.right}} & MASK_RIGHT)
                  | ({WIN_W{r_s1_edges.top}} & MASK_TOP)
                  | ({WIN_W{r_s1_edges.bottom}} & MASK_BOTTOM);
        cell_bits = (win_next & ~mask) | (mask & {WIN_W{r_edge_walls}});
        count     = '0;
        for (int i = 0; i < WIN_W; i++) begin
            if (i != WIN_CENTRE) begin
                count = count + t_count'(cell_bits[i]);
            end
        end
        judged = win_next[WIN_CENTRE] ? (count >= r_survive_min) : (count >= r_birth_min);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_survive_min <= SURVIVE_MIN_RST;
            r_birth_min   <= BIRTH_MIN_RST;
            r_edge_walls  <= EDGE_WALLS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[GRID_WIDTH_W-1:0];
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[GRID_HEIGHT_W-1:0];
                CFG_SURVIVE_MIN: r_survive_min <= i_cfg_data[THRESH_W-1:0];
                CFG_BIRTH_MIN:   r_birth_min   <= i_cfg_data[THRESH_W-1:0];
                CFG_EDGE_WALLS:  r_edge_walls  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_lb_upper[r_s1_col]  <= r_mid_bit;
            r_lb_middle[r_s1_col] <= r_s1_v;
        end
        if (load_s1) begin
            r_up_bit  <= r_lb_upper[a_col];
            r_mid_bit <= r_lb_middle[a_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_active   <= 1'b0;
            r_window   <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (load_s1) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_active   <= n_active;
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_window <= win_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_s1_emit  <= a_emit;
            r_s1_last  <= a_last;
            r_s1_fs    <= fs_eff;
            r_s1_v     <= a_v;
            r_s1_col   <= a_col;
            r_s1_ccol  <= CW'(ccol_ext);
            r_s1_crow  <= ORW'(crow_ext);
            r_s1_edges <= a_edges;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_emit) begin
            r_new_wall   <= judged;
            r_out_col    <= r_s1_ccol;
            r_out_row    <= r_s1_crow;
            r_frame_last <= r_s1_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_new_wall   = r_new_wall;
    assign o_out_col    = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_frame_last = r_frame_last;

    `CAS_ASSERT_SAME(a_stall_when_blocked,
                     r_s1_valid && r_s1_emit && r_out_valid && i_out_stall, o_in_stall,
                     "judging stage overrun while the result register is blocked")
    `CAS_ASSERT_SAME(a_last_ends_frame, r_s1_valid && r_s1_last, !r_active,
                     "frame still active behind its last cell")
    `CAS_ASSERT_NEXT(a_result_registered, s1_move && r_s1_emit, r_out_valid,
                     "judged cell did not reach the result register")
    `CAS_ASSERT_SAME(a_result_in_grid, r_out_valid,
                     (WCW'(r_out_col) < w_ext) && (HCW'(r_out_row) < h_ext),
                     "result position outside the grid")

endmodule

`default_nettype wire

### tb/tb_cave_automaton_smoothing_step.sv
`timescale 1ns / 1ps

module tb_cave_automaton_smoothing_step;
    import cas_pkg::*;

    localparam int MAX_W          = 128;
    localparam int MAX_H          = 1024;
    localparam int COL_W          = $clog2(MAX_W);
    localparam int ROW_W          = $clog2(MAX_H);
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 8;
    localparam int END_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int RANDOM_ITEMS   = 370;
    localparam int MAX_IDLE       = 11;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIRECTED_ROWS  = 30;

    typedef enum logic [1:0] {
        CHK_NONE,
        CHK_MODEL,
        CHK_FIXED
    } t_check_kind;

    typedef struct packed {
        logic             new_wall;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_cell_result;

    typedef struct packed {
        logic         mode;
        logic         wall;
        logic         start;
        t_check_kind  kind;
        t_cell_result want;
    } t_directed_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_mode = MODE_CELL;
    logic                   i_cell_wall = 1'b0;
    logic                   i_frame_start = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_new_wall;
    logic [COL_W-1:0]       o_out_col;
    logic [ROW_W-1:0]       o_out_row;
    logic                   o_frame_last;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    cave_automaton_smoothing_step #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_cell_wall  (i_cell_wall),
        .i_frame_start(i_frame_start),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_new_wall   (o_new_wall),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Register copies and stream state of the smoothing predictor.
    logic [GRID_WIDTH_W-1:0]  cfg_width;
    logic [GRID_HEIGHT_W-1:0] cfg_height;
    logic [THRESH_W-1:0]      cfg_survive;
    logic [THRESH_W-1:0]      cfg_birth;
    logic                     cfg_edge_walls;

    logic        upper_row_bits [MAX_W];
    logic        middle_row_bits [MAX_W];
    t_window     window;
    int unsigned col_pos;
    int unsigned row_pos;
    logic        frame_open;

    t_cell_result pending_results [$];
    int           mismatch_count = 0;
    int unsigned  items_accepted = 0;
    logic         tx_no_idle = 1'b0;
    logic         rx_no_idle = 1'b0;
    logic         frame_left_open = 1'b0;
    int           stall_left = 0;
    int           quiet_cycles = 0;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{MODE_FLUSH, 1'b0, 1'b1, CHK_NONE,  '0},
        '{MODE_CELL,  1'b1, 1'b0, CHK_NONE,  '0},
        '{MODE_CELL,  1'b1, 1'b1, CHK_NONE,  '0},
        '{MODE_CELL,  1'b1, 1'b0, CHK_NONE,  '0},
        '{MODE_CELL,  1'b1, 1'b0, CHK_NONE,  '0},
        '{MODE_CELL,  1'b1, 1'b0, CHK_NONE,  '0},
        '{MODE_CELL,  1'b1, 1'b0, CHK_FIXED, '{1'b1, 7'd0, 10'd0, 1'b0}},
        '{MODE_CELL,  1'b1, 1'b0, CHK_FIXED, '{1'b1, 7'd1, 10'd0, 1'b0}},
        '{MODE_CELL,  1'b1, 1'b0, CHK_FIXED, '{1'b1, 7'd2, 10'd0, 1'b0}},
        '{MODE_CELL,  1'b1, 1'b0, CHK_FIXED, '{1'b1, 7'd0, 10'd1, 1'b0}},
        '{MODE_CELL,  1'b1, 1'b0, CHK_FIXED, '{1'b1, 7'd1, 10'd1, 1'b0}},
        '{MODE_FLUSH, 1'b0, 1'b0, CHK_FIXED, '{1'b1, 7'd2, 10'd1, 1'b0}},
        '{MODE_FLUSH, 1'b1, 1'b0, CHK_FIXED, '{1'b1, 7'd0, 10'd2, 1'b0}},
        '{MODE_FLUSH, 1'b0, 1'b0, CHK_FIXED, '{1'b1, 7'd1, 10'd2, 1'b0}},
        '{MODE_FLUSH, 1'b0, 1'b0, CHK_FIXED, '{1'b1, 7'd2, 10'd2, 1'b1}},
        '{MODE_CELL,  1'b0, 1'b1, CHK_MODEL, '0},
        '{MODE_CELL,  1'b1, 1'b1, CHK_MODEL, '0},
        '{MODE_CELL,  1'b0, 1'b0, CHK_MODEL, '0},
        '{MODE_CELL,  1'b1, 1'b0, CHK_MODEL, '0},
        '{MODE_FLUSH, 1'b1, 1'b0, CHK_MODEL, '0},
        '{MODE_CELL,  1'b1, 1'b0, CHK_MODEL, '0},
        '{MODE_CELL,  1'b0, 1'b0, CHK_MODEL, '0},
        '{MODE_CELL,  1'b1, 1'b0, CHK_MODEL, '0},
        '{MODE_CELL,  1'b1, 1'b0, CHK_MODEL, '0},
        '{MODE_CELL,  1'b0, 1'b0, CHK_MODEL, '0},
        '{MODE_FLUSH, 1'b0, 1'b1, CHK_MODEL, '0},
        '{MODE_FLUSH, 1'b1, 1'b0, CHK_MODEL, '0},
        '{MODE_FLUSH, 1'b0, 1'b0, CHK_MODEL, '0},
        '{MODE_FLUSH, 1'b0, 1'b0, CHK_MODEL, '0},
        '{MODE_CELL,  1'b1, 1'b0, CHK_NONE,  '0}
    };

    function automatic int unsigned width_in_use();
        if (cfg_width < 3) return 3;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic int unsigned height_in_use();
        if (cfg_height < 3) return 3;
        if (cfg_height > MAX_H) return MAX_H;
        return cfg_height;
    endfunction

    function automatic logic smooth_cell(input logic mode, input logic wall, input logic start,
                                         output t_cell_result res);
        logic        v;
        logic        up;
        logic        mid;
        logic        has;
        logic        outside;
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned ccol;
        int unsigned crow;
        int unsigned count;
        v = (mode == MODE_CELL) ? wall : 1'b0;
        w = width_in_use();
        h = height_in_use();
        res = '0;
        ccol = 0;
        crow = 0;
        if (mode == MODE_CELL && start) begin
            col_pos = 0;
            row_pos = 0;
            window = '0;
            frame_open = 1'b1;
        end
        if (!frame_open) return 1'b0;
        c = col_pos;
        r = row_pos;
        up = upper_row_bits[c];
        mid = middle_row_bits[c];
        upper_row_bits[c] = mid;
        middle_row_bits[c] = v;
        window = {v, mid, up, window[WIN_W-1:3]};
        has = 1'b0;
        if (c >= 1 && r >= 1) begin
            has = 1'b1;
            crow = r - 1;
            ccol = c - 1;
        end else if (c == 0 && r >= 2) begin
            has = 1'b1;
            crow = r - 2;
            ccol = w - 1;
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = r + 1;
        end else begin
            col_pos = c + 1;
        end
        if (!has) return 1'b0;
        if (crow >= h) begin
            frame_open = 1'b0;
            return 1'b0;
        end
        if (ccol >= w) return 1'b0;
        count = 0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                if (k * 3 + j != WIN_CENTRE) begin
                    outside = (k == 0 && ccol == 0) || (k == 2 && ccol == w - 1) ||
                              (j == 0 && crow == 0) || (j == 2 && crow == h - 1);
                    count += outside ? cfg_edge_walls : window[k * 3 + j];
                end
            end
        end
        res.new_wall = window[WIN_CENTRE] ? (count >= cfg_survive) : (count >= cfg_birth);
        res.col = COL_W'(ccol);
        res.row = ROW_W'(crow);
        res.last = (crow == h - 1 && ccol == w - 1);
        if (res.last) frame_open = 1'b0;
        return 1'b1;
    endfunction

    task automatic write_reg(input t_cfg_index idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_GRID_WIDTH: begin
                cfg_width = data[GRID_WIDTH_W-1:0];
            end
            CFG_GRID_HEIGHT: begin
                cfg_height = data[GRID_HEIGHT_W-1:0];
            end
            CFG_SURVIVE_MIN: begin
                cfg_survive = data[THRESH_W-1:0];
            end
            CFG_BIRTH_MIN: begin
                cfg_birth = data[THRESH_W-1:0];
            end
            CFG_EDGE_WALLS: begin
                cfg_edge_walls = data[0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_item(input logic mode, input logic wall, input logic start,
                             input t_check_kind kind, input t_cell_result fixed);
        t_cell_result predicted;
        logic         has;
        int           gap;
        i_mode <= mode;
        i_cell_wall <= wall;
        i_frame_start <= start;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_accepted++;
        has = smooth_cell(mode, wall, start, predicted);
        if (kind == CHK_FIXED) begin
            pending_results.push_back(fixed);
        end else if (kind == CHK_MODEL && has) begin
            pending_results.push_back(predicted);
        end
        if ($urandom_range(0, 39) == 0) tx_no_idle = !tx_no_idle;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int p);
        int unsigned wv;
        int unsigned hv;
        int unsigned junk;
        int unsigned w;
        int unsigned h;
        int unsigned frames;
        int unsigned cut_at;
        int unsigned density;
        int unsigned n;
        logic        clean;
        logic        cut;
        logic        mode;
        logic        start;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (p == 0) begin
            wv = 255;
            hv = 3;
        end else if (p == 1) begin
            wv = 2;
            hv = 0;
        end else begin
            case ($urandom_range(0, 39))
                0: wv = $urandom_range(0, 2);
                1: wv = $urandom_range(11, 16);
                default: wv = $urandom_range(3, 10);
            endcase
            hv = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
        end
        junk = (p >= 2 && $urandom_range(0, 3) == 0) ? $urandom : 0;
        write_reg(CFG_GRID_WIDTH, wv | (junk << GRID_WIDTH_W));
        write_reg(CFG_GRID_HEIGHT, hv);
        write_reg(CFG_SURVIVE_MIN, (($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) :
                                    $urandom_range(3, 6)) | (junk << THRESH_W));
        write_reg(CFG_BIRTH_MIN, (($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) :
                                  $urandom_range(3, 6)) | (junk << THRESH_W));
        write_reg(CFG_EDGE_WALLS, $urandom_range(0, 1) | (junk << 1));
        if (p >= 2 && $urandom_range(0, 3) == 0) begin
            write_reg(t_cfg_index'($urandom_range(CFG_EDGE_WALLS + 1, (1 << CFG_INDEX_W) - 1)),
                      $urandom);
        end
        i_cfg_valid <= 1'b0;
        w = width_in_use();
        h = height_in_use();

        if (frame_left_open) begin
            n = $urandom_range(1, 2 * w);
            for (int i = 0; i < n; i++) begin
                send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
                          CHK_MODEL, '0);
            end
            frame_left_open = 1'b0;
        end

        frames = (p < 2) ? 1 : $urandom_range(1, 3);
        for (int f = 0; f < frames; f++) begin
            clean = (p < 2) || ($urandom_range(0, 9) < 7);
            cut = (p >= 2) && (f == frames - 1) && ($urandom_range(0, 4) == 0);
            cut_at = cut ? $urandom_range(1, w * h - 1) : w * h;
            case ($urandom_range(0, 9))
                0: density = 100;
                1: density = 0;
                default: density = $urandom_range(20, 80);
            endcase
            for (int i = 0; i < cut_at; i++) begin
                mode = MODE_CELL;
                start = (i == 0);
                if (!clean && i != 0) begin
                    n = $urandom_range(0, 99);
                    if (n < 2) begin
                        mode = MODE_FLUSH;
                    end else if (n == 2) begin
                        start = 1'b1;
                    end else if (n == 3) begin
                        mode = MODE_FLUSH;
                        start = 1'b1;
                    end
                end
                send_item(mode, ($urandom_range(0, 99) < density), start, CHK_MODEL, '0);
            end
            if (cut) begin
                frame_left_open = 1'b1;
            end else begin
                for (int i = 0; i <= w; i++) begin
                    mode = (!clean && $urandom_range(0, 9) == 0) ? MODE_CELL : MODE_FLUSH;
                    start = (mode == MODE_FLUSH) ? 1'($urandom_range(0, 1)) : 1'b0;
                    send_item(mode, 1'($urandom_range(0, 1)), start, CHK_MODEL, '0);
                end
                n = clean ? 0 : $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    mode = 1'($urandom_range(0, 1));
                    start = (mode == MODE_FLUSH) ? 1'($urandom_range(0, 1)) : 1'b0;
                    send_item(mode, 1'($urandom_range(0, 1)), start, CHK_MODEL, '0);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_cell_result got;
        t_cell_result want;
        int           hold;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            got = {o_new_wall, o_out_col, o_out_row, o_frame_last};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("Unexpected transaction: wall %0d col %0d row %0d last %0d",
                             got.new_wall, got.col, got.row, got.last);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("Mismatch: expected wall %0d col %0d row %0d last %0d, %s",
                                 want.new_wall, want.col, want.row, want.last,
                                 $sformatf("got wall %0d col %0d row %0d last %0d",
                                           got.new_wall, got.col, got.row, got.last));
                    end
                end
            end
            if ($urandom_range(0, 39) == 0) rx_no_idle = !rx_no_idle;
            hold = rx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            stall_left <= hold;
            i_out_stall <= (hold != 0);
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int          p;
        int unsigned random_base;
        cfg_width = GRID_WIDTH_RST;
        cfg_height = GRID_HEIGHT_RST;
        cfg_survive = SURVIVE_MIN_RST;
        cfg_birth = BIRTH_MIN_RST;
        cfg_edge_walls = EDGE_WALLS_RST;
        window = '0;
        col_pos = 0;
        row_pos = 0;
        frame_open = 1'b0;
        for (int i = 0; i < MAX_W; i++) begin
            upper_row_bits[i] = 1'b0;
            middle_row_bits[i] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The table assumes a 3x3 grid with the default thresholds and walls outside.
        write_reg(CFG_GRID_WIDTH, 3);
        write_reg(CFG_GRID_HEIGHT, 3);
        write_reg(CFG_SURVIVE_MIN, SURVIVE_MIN_RST);
        write_reg(CFG_BIRTH_MIN, BIRTH_MIN_RST);
        write_reg(CFG_EDGE_WALLS, EDGE_WALLS_RST);
        i_cfg_valid <= 1'b0;
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].mode, directed_rows[i].wall, directed_rows[i].start,
                      directed_rows[i].kind, directed_rows[i].want);
        end

        // The first wide frame writes every line buffer entry before any shrink or growth.
        run_phase(0);
        run_phase(1);
        random_base = items_accepted;
        p = 2;
        while (items_accepted - random_base < RANDOM_ITEMS) begin
            run_phase(p);
            p++;
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/cas_pkg.sv
hdl/cave_automaton_smoothing_step.sv
tb/tb_cave_automaton_smoothing_step.sv
